@@ hw/rtl/line_dot_walker_core_assert.svh @@
// ---------------------------------------------------------------------------
// line_dot_walker_core_assert.svh
// Assertion macros shared by the line dot walker RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_DOT_WALKER_CORE_ASSERT_SVH
`define LINE_DOT_WALKER_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define LDW_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("line dot walker: same-cycle check failed");

// Condition implies consequence in the following cycle.
`define LDW_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("line dot walker: next-cycle check failed");

`endif

@@ hw/rtl/ldw_pkg.sv @@
// ---------------------------------------------------------------------------
// ldw_pkg
// Types and constants of the line dot walker.
// ---------------------------------------------------------------------------
package ldw_pkg;

   // Quotient width of the serial divider; one quotient bit per cycle
   localparam int QUO_W     = 7;
   localparam int PROD_W    = 2 * QUO_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = 3;

   // Request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   // How the dots of a line are found
   typedef enum logic [1:0] {
      MODE_VERT  = 2'd0,
      MODE_HORZ  = 2'd1,
      MODE_SHAL  = 2'd2,
      MODE_STEEP = 2'd3
   } line_mode_type;

   // Divider request
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [QUO_W-1:0]  divisor;
   } div_ctl_type;

   // Divider result
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic             rem_nz;
   } div_sts_type;

endpackage

@@ hw/rtl/ldw_serial_div.sv @@
// ---------------------------------------------------------------------------
// ldw_serial_div
// Restoring divider, one quotient bit per cycle. The dividend must be
// below divisor * 2^QUO_W, so its upper half seeds the partial remainder.
// ---------------------------------------------------------------------------
`include "line_dot_walker_core_assert.svh"

module ldw_serial_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ldw_pkg::div_ctl_type ctl,
   output ldw_pkg::div_sts_type sts
);

   localparam int QW = ldw_pkg::QUO_W;
   localparam int CW = ldw_pkg::CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] shf_ff, shf_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [QW-1:0] den_ff, den_in;

   logic [QW:0]   trial;
   logic [QW:0]   diff;
   logic          fits;
   logic          last_step;

   // One restoring step: bring down the next dividend bit, try the subtract
   always_comb begin
      trial     = {rem_ff, shf_ff[QW-1]};
      diff      = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      last_step = cnt_ff == CW'(ldw_pkg::DIV_STEPS - 1);
   end

   // Next values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = ctl.dividend[ldw_pkg::PROD_W-1:QW];
         shf_in  = ctl.dividend[QW-1:0];
         den_in  = ctl.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CW'(1);
         rem_in = fits ? diff[QW-1:0] : trial[QW-1:0];
         shf_in = {shf_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
   assign sts.rem_nz   = |rem_ff;

   `LDW_ASSERT_NEXT(a_div_start_busy, clock, reset, ctl.start, busy_ff)
   `LDW_ASSERT_SAME(a_div_rem_below, clock, reset, busy_ff, rem_ff < den_ff)
   `LDW_ASSERT_NEXT(a_div_done_after_last, clock, reset,
                    busy_ff && last_step && !ctl.start, done_ff && !busy_ff)

endmodule

@@ hw/rtl/line_dot_walker_core.sv @@
// ---------------------------------------------------------------------------
// line_dot_walker_core
// Walks the dots of a straight line on a page-organized display, one dot
// per beat of an active line. A start beat loads it and gives its first dot.
// ---------------------------------------------------------------------------
//  channel  ports            direction  handshake
//  request  req_*            in         req_valid / req_ready
//  response rsp_*            out        rsp_valid / rsp_ready
//
// Sloped lines: each accepted beat runs through ST_MUL (product), the
// bit-serial divider in ST_DIV (until its done hand-off) and ST_FIN
// (output load). Vertical and horizontal lines go from ST_MUL to ST_FIN.
// One beat in flight; req_ready is high only while no beat is at work.
// The output register lets a finished dot wait while the next beat runs;
// a dot that finds it full holds in the final state until rsp_ready.
// Synchronous active-high reset clears the walker and the output valid.
// ---------------------------------------------------------------------------
`include "line_dot_walker_core_assert.svh"

module line_dot_walker_core #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [6:0] req_x_start,
   input  logic [5:0] req_y_start,
   input  logic [6:0] req_x_end,
   input  logic [5:0] req_y_end,
   input  logic       req_draw,
   input  logic [7:0] req_stride,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_column,
   output logic [2:0] rsp_page,
   output logic [7:0] rsp_page_byte,
   output logic       rsp_last
);

   localparam logic [8:0] X_LIM = 9'(SCREEN_WIDTH - 1);
   localparam logic [8:0] Y_LIM = 9'(SCREEN_HEIGHT - 1);
   localparam int         QW    = ldw_pkg::QUO_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic                   active_ff, active_in;
   ldw_pkg::line_mode_type mode_ff;
   logic [6:0]             pos_ff;
   logic [6:0]             end_ff;
   logic [6:0]             ax_ff;
   logic [5:0]             ay_ff;
   logic [6:0]             dx_ff;
   logic [5:0]             ady_ff;
   logic                   dy_neg_ff;
   logic                   draw_ff;
   logic [7:0]             stride_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [6:0]             column_ff;
   logic [2:0]             page_ff;
   logic [7:0]             page_byte_ff;
   logic                   last_ff;

   logic                   req_fire;
   logic                   start_fire;
   logic                   fin_load;
   logic                   sloped;

   ldw_pkg::div_ctl_type   div_ctl;
   ldw_pkg::div_sts_type   div_sts;

   // Start beat: clamp, order endpoints by x, classify
   logic [6:0]             xs_c, xe_c, xa, xb;
   logic [5:0]             ys_c, ye_c, ya, yb;
   logic                   swap;
   logic [6:0]             st_dx;
   logic [5:0]             st_ady;
   logic                   st_dy_neg;
   ldw_pkg::line_mode_type st_mode;
   logic [6:0]             st_pos, st_end;
   logic [7:0]             st_stride;

   always_comb begin
      xs_c      = ({2'b00, req_x_start} > X_LIM) ? X_LIM[6:0] : req_x_start;
      xe_c      = ({2'b00, req_x_end} > X_LIM)   ? X_LIM[6:0] : req_x_end;
      ys_c      = ({3'b000, req_y_start} > Y_LIM) ? Y_LIM[5:0] : req_y_start;
      ye_c      = ({3'b000, req_y_end} > Y_LIM)   ? Y_LIM[5:0] : req_y_end;
      swap      = xs_c > xe_c;
      xa        = swap ? xe_c : xs_c;
      xb        = swap ? xs_c : xe_c;
      ya        = swap ? ye_c : ys_c;
      yb        = swap ? ys_c : ye_c;
      st_dx     = xb - xa;
      st_dy_neg = yb < ya;
      st_ady    = st_dy_neg ? (ya - yb) : (yb - ya);
      if (st_dx == '0) begin
         st_mode = ldw_pkg::MODE_VERT;
      end else if (st_ady == '0) begin
         st_mode = ldw_pkg::MODE_HORZ;
      end else if ({1'b0, st_ady} < st_dx) begin
         st_mode = ldw_pkg::MODE_SHAL;
      end else begin
         st_mode = ldw_pkg::MODE_STEEP;
      end
      if (st_mode == ldw_pkg::MODE_HORZ || st_mode == ldw_pkg::MODE_SHAL) begin
         st_pos = xa;
         st_end = xb;
      end else begin
         st_pos = {1'b0, st_dy_neg ? yb : ya};
         st_end = {1'b0, st_dy_neg ? ya : yb};
      end
      st_stride = (req_stride == '0) ? 8'd1 : req_stride;
   end

   assign req_ready  = state_ff == ST_IDLE;
   assign req_fire   = req_valid && req_ready;
   assign start_fire = req_fire && (req_op == ldw_pkg::OP_START);
   assign sloped     = mode_ff == ldw_pkg::MODE_SHAL || mode_ff == ldw_pkg::MODE_STEEP;
   assign fin_load   = state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready);

   // Product along the stepped axis, then divide by the driving delta
   logic [QW-1:0] mul_a, mul_b;

   always_comb begin
      if (mode_ff == ldw_pkg::MODE_SHAL) begin
         mul_a           = {1'b0, ady_ff};
         mul_b           = pos_ff - ax_ff;
         div_ctl.divisor = dx_ff;
      end else begin
         mul_a           = dx_ff;
         mul_b           = dy_neg_ff ? ({1'b0, ay_ff} - pos_ff) : (pos_ff - {1'b0, ay_ff});
         div_ctl.divisor = {1'b0, ady_ff};
      end
      div_ctl.dividend = mul_a * mul_b;
      div_ctl.start    = state_ff == ST_MUL && sloped;
   end

   ldw_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   // Dot coordinates from the quotient (sloped lines) or from the position alone
   logic [7:0] row_up, row_dn, col_sum;
   logic [6:0] dot_col;
   logic [5:0] dot_row;
   logic [8:0] pos_next;
   logic       dot_last;

   always_comb begin
      row_up  = {2'b00, ay_ff} + {1'b0, div_sts.quotient};
      row_dn  = {2'b00, ay_ff} - {1'b0, div_sts.quotient} - {7'd0, div_sts.rem_nz};
      col_sum = {1'b0, ax_ff} + {1'b0, div_sts.quotient};
      case (mode_ff)
         ldw_pkg::MODE_VERT: begin
            dot_col = ax_ff;
            dot_row = pos_ff[5:0];
         end
         ldw_pkg::MODE_HORZ: begin
            dot_col = pos_ff;
            dot_row = ay_ff;
         end
         ldw_pkg::MODE_SHAL: begin
            dot_col = pos_ff;
            dot_row = dy_neg_ff ? row_dn[5:0] : row_up[5:0];
         end
         default: begin
            dot_col = col_sum[6:0];
            dot_row = pos_ff[5:0];
         end
      endcase
      pos_next = {2'b00, pos_ff} + {1'b0, stride_ff};
      dot_last = pos_next > {2'b00, end_ff};
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_fire) begin
               state_in  = ST_MUL;
               active_in = 1'b1;
            end else if (req_fire && active_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = sloped ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_load) begin
               state_in = ST_IDLE;
               if (dot_last) begin
                  active_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         mode_ff   <= ldw_pkg::MODE_VERT;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         if (start_fire) begin
            mode_ff <= st_mode;
         end
      end
   end

   // Line registers
   always_ff @(posedge clock) begin
      if (start_fire) begin
         pos_ff    <= st_pos;
         end_ff    <= st_end;
         ax_ff     <= xa;
         ay_ff     <= ya;
         dx_ff     <= st_dx;
         ady_ff    <= st_ady;
         dy_neg_ff <= st_dy_neg;
         draw_ff   <= req_draw;
         stride_ff <= st_stride;
      end else if (fin_load && !dot_last) begin
         pos_ff <= pos_next[6:0];
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         column_ff    <= dot_col;
         page_ff      <= dot_row[5:3];
         page_byte_ff <= draw_ff ? (8'd1 << dot_row[2:0]) : 8'd0;
         last_ff      <= dot_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_column    = column_ff;
   assign rsp_page      = page_ff;
   assign rsp_page_byte = page_byte_ff;
   assign rsp_last      = last_ff;

   `LDW_ASSERT_SAME(a_done_in_div, clock, reset, div_sts.done, state_ff == ST_DIV)
   `LDW_ASSERT_NEXT(a_rsp_from_fin, clock, reset,
                    !rsp_valid_ff && state_ff != ST_FIN, !rsp_valid_ff)
   `LDW_ASSERT_NEXT(a_last_drops_line, clock, reset,
                    fin_load && dot_last, !active_ff && rsp_last && rsp_valid)

endmodule
